[hdl/ccd_pkg.sv]
// ============================================================================
// Context change detector package
// Operation codes, register indexes and shared types for the detector.
// ============================================================================
`default_nettype none

package ccd_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned SymW     = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned LimitW   = 8;
  localparam int unsigned WordMapW = 256;

  localparam logic [LimitW-1:0] LimitReset = LimitW'(80);

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_WINDOW = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WORD_CHARS_0 = 3'd0,
    REG_WORD_CHARS_1 = 3'd1,
    REG_WORD_CHARS_2 = 3'd2,
    REG_WORD_CHARS_3 = 3'd3,
    REG_WINDOW_LIMIT = 3'd4
  } reg_idx_e;

  typedef logic [SymW-1:0] sym_t;

  typedef struct packed {
    logic text_nonempty;
    logic matched;
    logic rem_nonempty;
    logic rem_has_word;
    logic rem_last_word;
  } text_status_t;

endpackage

`default_nettype wire

[hdl/ccd_if.sv]
// ============================================================================
// Context change detector channels
// Valid/ready channels for input transactions and result transactions.
// ============================================================================
`default_nettype none

interface ccd_in_if;
  import ccd_pkg::*;

  logic            valid;
  logic            ready;
  logic [OpW-1:0]  op;
  logic [SymW-1:0] symbol;

  modport source (output valid, output op, output symbol, input ready);
  modport sink   (input valid, input op, input symbol, output ready);
endinterface

interface ccd_out_if;
  logic valid;
  logic ready;
  logic change_flag;

  modport source (output valid, output change_flag, input ready);
  modport sink   (input valid, input change_flag, output ready);
endinterface

`default_nettype wire

[hdl/ccd_window.sv]
// ============================================================================
// Context change detector window store
// Shift store of the latest window bytes with fill count and window length.
// ============================================================================
`default_nettype none

module ccd_window #(
  parameter int unsigned MaxWindow = 128
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   en_i,
  input  wire ccd_pkg::op_e                           op_i,
  input  wire ccd_pkg::sym_t                          sym_i,
  input  wire logic [ccd_pkg::LimitW-1:0]             limit_i,
  output logic [MaxWindow-1:0][ccd_pkg::SymW-1:0]     store_o,
  output logic [$clog2(MaxWindow+1)-1:0]              len_o
);
  import ccd_pkg::*;

  localparam int unsigned CntW = $clog2(MaxWindow + 1);
  localparam int unsigned CmpW = (CntW > LimitW) ? CntW : LimitW;
  localparam logic [CmpW-1:0] MaxCmp = CmpW'(MaxWindow);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxWindow);

  logic [MaxWindow-1:0][SymW-1:0] store_q;
  logic [CntW-1:0]                fill_q, fill_d;
  logic [CntW-1:0]                len_q, len_d;
  logic [CmpW-1:0]                limit_ext;
  logic [CntW-1:0]                lim;

  always_comb begin
    limit_ext = CmpW'(limit_i);
    lim       = (limit_ext > MaxCmp) ? MaxCnt : CntW'(limit_ext);
    fill_d    = fill_q;
    len_d     = len_q;
    if (en_i) begin
      case (op_i)
        OP_CLEAR: begin
          fill_d = '0;
          len_d  = '0;
        end
        OP_WINDOW: begin
          fill_d = (fill_q < MaxCnt) ? fill_q + CntW'(1) : fill_q;
          len_d  = (fill_d < lim) ? fill_d : lim;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      len_q  <= '0;
    end else begin
      fill_q <= fill_d;
      len_q  <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && (op_i == OP_WINDOW)) begin
      for (int unsigned i = 0; i + 1 < MaxWindow; i++) begin
        store_q[i] <= store_q[i+1];
      end
      store_q[MaxWindow-1] <= sym_i;
    end
  end

  assign store_o = store_q;
  assign len_o   = len_q;

endmodule

`default_nettype wire

[hdl/ccd_text.sv]
// ============================================================================
// Context change detector text tracker
// Text history, parallel window compare and remainder status flags.
// ============================================================================
`default_nettype none

module ccd_text #(
  parameter int unsigned MaxWindow = 128
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   en_i,
  input  wire ccd_pkg::op_e                           op_i,
  input  wire ccd_pkg::sym_t                          sym_i,
  input  wire logic                                   sym_word_i,
  input  wire logic [MaxWindow-1:0][ccd_pkg::SymW-1:0] window_i,
  input  wire logic [$clog2(MaxWindow+1)-1:0]         len_i,
  output ccd_pkg::text_status_t                       status_o
);
  import ccd_pkg::*;

  localparam int unsigned CntW = $clog2(MaxWindow + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxWindow);

  logic [MaxWindow-1:0][SymW-1:0] hist_q;
  logic [MaxWindow-1:0][SymW-1:0] hist_shift;
  logic [MaxWindow-1:0]           pos_ok;
  logic [CntW-1:0]                count_q, count_d;
  logic                           hit;
  text_status_t                   stat_q, stat_d;

  always_comb begin
    for (int unsigned i = 0; i + 1 < MaxWindow; i++) begin
      hist_shift[i] = hist_q[i+1];
    end
    hist_shift[MaxWindow-1] = sym_i;
    for (int unsigned i = 0; i < MaxWindow; i++) begin
      pos_ok[i] = (hist_shift[i] == window_i[i]) ||
                  (CntW'(MaxWindow - 1 - i) >= len_i);
    end
  end

  always_comb begin
    count_d = count_q;
    stat_d  = stat_q;
    hit     = 1'b0;
    if (en_i) begin
      case (op_i)
        OP_TEXT: begin
          count_d = (count_q < MaxCnt) ? count_q + CntW'(1) : count_q;
          hit     = (len_i != '0) && (count_d >= len_i) && (&pos_ok);
          stat_d.text_nonempty = 1'b1;
          if (hit) begin
            stat_d.matched       = 1'b1;
            stat_d.rem_nonempty  = 1'b0;
            stat_d.rem_has_word  = 1'b0;
            stat_d.rem_last_word = 1'b0;
          end else begin
            stat_d.rem_nonempty  = 1'b1;
            stat_d.rem_has_word  = stat_q.rem_has_word | sym_word_i;
            stat_d.rem_last_word = sym_word_i;
          end
        end
        OP_END: begin
          count_d = '0;
          stat_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      stat_q  <= '0;
    end else begin
      count_q <= count_d;
      stat_q  <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && (op_i == OP_TEXT)) begin
      hist_q <= hist_shift;
    end
  end

  assign status_o = stat_q;

endmodule

`default_nettype wire

[hdl/context_change_detector.sv]
// ============================================================================
// Context change detector
// Tracks a window of earlier text and reports whether the current text has
// moved away from the last occurrence of that window.
// ============================================================================
// Result path: an end-of-text transaction is held in the input register at
// acceptance, and its result is captured in the result register when it advances.
// Throughput: one input transaction per cycle; the window compare over all
// MaxWindow byte positions is done in parallel in the decode stage. A stalled
// result holds a following end-of-text transaction in the input register.
// Reset clears all control state at once; no clearing pass is needed.
`default_nettype none

module context_change_detector #(
  parameter int unsigned MaxWindow = 128
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [ccd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [ccd_pkg::CfgDataW-1:0]      cfg_data_i,
  ccd_in_if.sink                                 in_i,
  ccd_out_if.source                              out_o
);
  import ccd_pkg::*;

  localparam int unsigned CntW = $clog2(MaxWindow + 1);

  logic [WordMapW-1:0]            word_map_q;
  logic [LimitW-1:0]              limit_q;

  logic                           s1_valid_q;
  op_e                            s1_op_q;
  sym_t                           s1_sym_q;
  logic                           s1_adv;

  logic                           out_valid_q;
  logic                           out_flag_q;
  logic                           change;

  logic [MaxWindow-1:0][SymW-1:0] window;
  logic [CntW-1:0]                window_len;
  text_status_t                   text_stat;
  logic                           sym_word;
  logic                           window_last_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_map_q <= '0;
      limit_q    <= LimitReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_WORD_CHARS_0: word_map_q[63:0]    <= cfg_data_i;
        REG_WORD_CHARS_1: word_map_q[127:64]  <= cfg_data_i;
        REG_WORD_CHARS_2: word_map_q[191:128] <= cfg_data_i;
        REG_WORD_CHARS_3: word_map_q[255:192] <= cfg_data_i;
        REG_WINDOW_LIMIT: limit_q             <= cfg_data_i[LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign s1_adv = s1_valid_q &&
                  !((s1_op_q == OP_END) && out_valid_q && !out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_op_q  <= op_e'(in_i.op);
      s1_sym_q <= in_i.symbol;
    end
  end

  assign sym_word         = word_map_q[s1_sym_q];
  assign window_last_word = word_map_q[window[MaxWindow-1]];

  ccd_window #(
    .MaxWindow (MaxWindow)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s1_adv),
    .op_i    (s1_op_q),
    .sym_i   (s1_sym_q),
    .limit_i (limit_q),
    .store_o (window),
    .len_o   (window_len)
  );

  ccd_text #(
    .MaxWindow (MaxWindow)
  ) u_text (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (s1_adv),
    .op_i       (s1_op_q),
    .sym_i      (s1_sym_q),
    .sym_word_i (sym_word),
    .window_i   (window),
    .len_i      (window_len),
    .status_o   (text_stat)
  );

  always_comb begin
    if (window_len == '0) begin
      change = text_stat.text_nonempty;
    end else if (!text_stat.matched) begin
      change = 1'b1;
    end else if (!text_stat.rem_nonempty) begin
      change = 1'b0;
    end else if (text_stat.rem_has_word) begin
      change = !text_stat.rem_last_word;
    end else begin
      change = window_last_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && (s1_op_q == OP_END)) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (s1_op_q == OP_END)) begin
      out_flag_q <= change;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.change_flag = out_flag_q;

endmodule

`default_nettype wire

[hdl/ccd_checker.sv]
// ============================================================================
// Context change detector checker
// Port-level assertions on transaction ordering and output stalling.
// ============================================================================
`default_nettype none

module ccd_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_i,
  input wire logic [ccd_pkg::OpW-1:0] in_op_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_ready_i,
  input wire logic                   out_flag_i
);
  import ccd_pkg::*;

  logic in_accept;
  logic end_accept;

  assign in_accept  = in_valid_i && in_ready_i;
  assign end_accept = in_accept && (op_e'(in_op_i) == OP_END);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result transaction withdrawn while stalled");

  a_flag_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_flag_i))
    else $error("result payload changed while stalled");

  a_rise_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(end_accept, 2))
    else $error("result appeared without a preceding end-of-text transaction");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled while the result side is free");

endmodule

bind context_change_detector ccd_checker u_ccd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_flag_i  (out_o.change_flag)
);

`default_nettype wire
